// ===== src/llca_pkg.sv =====
`default_nettype none
package llca_pkg;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic [2:0] RULE_CONWAY    = 3'd0;
    localparam logic [2:0] RULE_DAY_NIGHT = 3'd1;
    localparam logic [2:0] RULE_NO_DEATH  = 3'd2;
    localparam logic [2:0] RULE_HIGHLIFE  = 3'd3;
    localparam logic [2:0] RULE_SEEDS     = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RULE   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_USE,
        ST_RD_LAST,
        ST_RD_ZERO,
        ST_RD_ONE,
        ST_RD_DONE,
        ST_CELL,
        ST_ROW,
        ST_ADV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_CELL,
        RD_LAST,
        RD_ZERO,
        RD_ONE,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_CELL,
        WR_ROW
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    ld_prev;
        logic    ld_cur;
        logic    ld_nxt;
        logic    cap_bit;
        logic    cell_en;
        logic    adv;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       clear_last;
        logic       x_last;
        logic       y_last;
    } t_status;

    // birth mask in the low nine bits, survival mask in the high nine
    function automatic logic [17:0] rule_masks(input logic [2:0] rule);
        logic [17:0] m;
        case (rule)
            RULE_CONWAY:    m = {9'h00C, 9'h008};
            RULE_DAY_NIGHT: m = {9'h1D8, 9'h1C8};
            RULE_NO_DEATH:  m = {9'h1FF, 9'h008};
            RULE_HIGHLIFE:  m = {9'h00C, 9'h048};
            RULE_SEEDS:     m = {9'h000, 9'h004};
            default:        m = {9'h00C, 9'h008};
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== src/llca_ctrl.sv =====
`default_nettype none
module llca_ctrl
    import llca_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    case (i_status.kind)
                        KIND_WRITE: n_state = ST_CELL_RD;
                        KIND_READ:  n_state = ST_CELL_RD;
                        KIND_STEP:  n_state = ST_RD_LAST;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_CELL_RD:  n_state = ST_CELL_USE;
            ST_CELL_USE: n_state = ST_DONE;
            ST_RD_LAST:  n_state = ST_RD_ZERO;
            ST_RD_ZERO:  n_state = ST_RD_ONE;
            ST_RD_ONE:   n_state = ST_RD_DONE;
            ST_RD_DONE:  n_state = ST_CELL;
            ST_CELL: begin
                if (i_status.x_last) n_state = ST_ROW;
            end
            ST_ROW: begin
                n_state = i_status.y_last ? ST_DONE : ST_ADV;
            end
            ST_ADV:  n_state = ST_CELL;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_CLEAR;
        endcase
    end

    // the item kind in status is taken straight from the input when a start is accepted while idle
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_CLEAR;
            end
            ST_IDLE: begin
                o_cmd.load = i_start;
            end
            ST_CELL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CELL;
            end
            ST_CELL_USE: begin
                o_cmd.cap_bit = 1'b1;
                o_cmd.wr_en   = (i_status.kind == KIND_WRITE);
                o_cmd.wr_sel  = WR_CELL;
            end
            ST_RD_LAST: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LAST;
            end
            ST_RD_ZERO: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_ZERO;
                o_cmd.ld_prev = 1'b1;
            end
            ST_RD_ONE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ONE;
                o_cmd.ld_cur = 1'b1;
            end
            ST_RD_DONE: begin
                o_cmd.ld_nxt = 1'b1;
            end
            ST_CELL: begin
                o_cmd.cell_en = 1'b1;
            end
            ST_ROW: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_ROW;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
            end
            ST_ADV: begin
                o_cmd.adv = 1'b1;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("block not busy clearing after reset");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_busy)
        else $error("busy after finishing a transaction");

endmodule
`default_nettype wire

// ===== src/llca_datapath.sv =====
`default_nettype none
module llca_datapath
    import llca_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire t_cmd                             i_cmd,
    output t_status                               o_status,
    input  wire logic [$clog2(MAX_WIDTH):0]       i_w_used,
    input  wire logic [$clog2(MAX_HEIGHT):0]      i_h_used,
    input  wire logic [2:0]                       i_rule,
    input  wire logic [1:0]                       i_kind,
    input  wire logic [5:0]                       i_col,
    input  wire logic [5:0]                       i_row,
    input  wire logic                             i_alive_in,
    output logic                                  o_done,
    output logic                                  o_alive_out,
    output logic [12:0]                           o_live_count,
    output logic [12:0]                           o_dead_count,
    output logic [12:0]                           o_changed_count,
    output logic [15:0]                           o_generation_number
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rdata;
    logic [RW-1:0]        rd_addr, wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic                 wr_en;

    logic [1:0]    r_kind;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_alive;
    logic          r_inside;
    logic          r_bit;

    logic [MAX_WIDTH-1:0] r_prev, r_cur, r_nxt, r_row0, r_newrow;
    logic [CW-1:0]        r_x;
    logic [RW-1:0]        r_y;
    logic [RW-1:0]        r_clr;
    logic [12:0]          r_live, r_dead, r_changed;
    logic [15:0]          r_gen;

    logic [CW-1:0]  xl, xr;
    logic [3:0]     ncount;
    logic [17:0]    masks;
    logic           self_bit, new_bit;
    logic [RW+1:0]  y_plus2;
    logic           next_wraps;

    assign y_plus2    = (RW+2)'(r_y) + (RW+2)'(2);
    assign next_wraps = (y_plus2 >= (RW+2)'(i_h_used));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_CELL: rd_addr = r_row;
            RD_LAST: rd_addr = RW'(i_h_used - 1'b1);
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = (i_h_used == 1) ? '0 : RW'(1);
            RD_NEXT: rd_addr = next_wraps ? '0 : RW'(y_plus2);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_data = r_newrow;
        wr_addr = r_y;
        wr_en   = i_cmd.wr_en;
        case (i_cmd.wr_sel)
            WR_CLEAR: begin
                wr_data = '0;
                wr_addr = r_clr;
            end
            WR_CELL: begin
                wr_data        = r_rdata;
                wr_data[r_col] = r_alive;
                wr_addr        = r_row;
                wr_en          = i_cmd.wr_en && r_inside;
            end
            WR_ROW: begin
                wr_data = r_newrow;
                wr_addr = r_y;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rdata <= r_mem[rd_addr];
    end

    // neighbourhood of the current cell, wrapped over the area in use
    always_comb begin
        xl       = (r_x == '0) ? CW'(i_w_used - 1'b1) : r_x - 1'b1;
        xr       = ((CW+1)'(r_x) == i_w_used - 1'b1) ? '0 : r_x + 1'b1;
        ncount   = 4'(r_prev[xl]) + 4'(r_prev[r_x]) + 4'(r_prev[xr])
                 + 4'(r_cur[xl]) + 4'(r_cur[xr])
                 + 4'(r_nxt[xl]) + 4'(r_nxt[r_x]) + 4'(r_nxt[xr]);
        self_bit = r_cur[r_x];
        masks    = rule_masks(i_rule);
        new_bit  = self_bit ? masks[9 + 32'(ncount)] : masks[ncount];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_col     <= CW'(i_col);
            r_row     <= RW'(i_row);
            r_alive   <= i_alive_in;
            r_inside  <= ((CW+8)'(i_col) < (CW+8)'(i_w_used))
                      && ((RW+8)'(i_row) < (RW+8)'(i_h_used));
            r_live    <= '0;
            r_dead    <= '0;
            r_changed <= '0;
        end
        if (i_cmd.cap_bit) r_bit <= r_inside && r_rdata[r_col];
        if (i_cmd.ld_prev) r_prev <= r_rdata;
        if (i_cmd.ld_cur) begin
            r_cur    <= r_rdata;
            r_row0   <= r_rdata;
            r_newrow <= r_rdata;
        end
        if (i_cmd.ld_nxt) begin
            r_nxt <= r_rdata;
            r_x   <= '0;
            r_y   <= '0;
        end
        if (i_cmd.cell_en) begin
            r_newrow[r_x] <= new_bit;
            r_x           <= r_x + 1'b1;
            r_live        <= r_live + 13'(new_bit);
            r_dead        <= r_dead + 13'(!new_bit);
            r_changed     <= r_changed + 13'(new_bit != self_bit);
        end
        if (i_cmd.adv) begin
            r_prev   <= r_cur;
            r_cur    <= r_nxt;
            r_newrow <= r_nxt;
            r_nxt    <= next_wraps ? r_row0 : r_rdata;
            r_x      <= '0;
            r_y      <= r_y + 1'b1;
        end
        if (i_cmd.finish) begin
            o_alive_out     <= (r_kind == KIND_READ) && r_bit;
            o_live_count    <= (r_kind == KIND_STEP) ? r_live : '0;
            o_dead_count    <= (r_kind == KIND_STEP) ? r_dead : '0;
            o_changed_count <= (r_kind == KIND_STEP) ? r_changed : '0;
            o_generation_number <= (r_kind == KIND_STEP) ? r_gen + 1'b1 : r_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_gen  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
            if (i_cmd.wr_en && i_cmd.wr_sel == WR_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cmd.finish && r_kind == KIND_STEP) r_gen <= r_gen + 1'b1;
        end
    end

    always_comb begin
        o_status.kind       = i_cmd.load ? i_kind : r_kind;
        o_status.clear_last = ((RW+1)'(r_clr) == (RW+1)'(MAX_HEIGHT - 1));
        o_status.x_last     = ((CW+1)'(r_x) == i_w_used - 1'b1);
        o_status.y_last     = ((RW+1)'(r_y) == i_h_used - 1'b1);
    end

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_done)
        else $error("finished transaction gave no strobe");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_gen_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_kind != KIND_STEP) |=> $stable(r_gen))
        else $error("generation moved on a cell transaction");

endmodule
`default_nettype wire

// ===== src/life_like_cellular_automaton_step.sv =====
`default_nettype none
// Life-like automaton on a toroidal board held in a row-wide memory with
// one read and one write port. Raise i_start while o_busy is low to hand over a transaction;
// its result appears for one cycle with o_done and cannot be held off, so
// capture it then. A write or read transaction reads the addressed row
// and then uses or rewrites its cell before the strobe. An advance reads
// three rows, then evaluates one cell a cycle through the rule unit, with
// each row written back after it and the window shifted between rows.
// After reset a clearing pass over all MAX_HEIGHT rows (one row a cycle)
// runs with o_busy high; configuration writes are taken throughout.
module life_like_cellular_automaton_step
    import llca_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // command transaction
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [5:0]  i_col,
    input  wire logic [5:0]  i_row,
    input  wire logic        i_alive_in,
    // result transaction
    output logic             o_done,
    output logic             o_alive_out,
    output logic [12:0]      o_live_count,
    output logic [12:0]      o_dead_count,
    output logic [12:0]      o_changed_count,
    output logic [15:0]      o_generation_number
);

    localparam int WUW = $clog2(MAX_WIDTH) + 1;
    localparam int HUW = $clog2(MAX_HEIGHT) + 1;

    logic [6:0] r_board_width;
    logic [6:0] r_board_height;
    logic [2:0] r_rule_select;

    logic [WUW-1:0] w_used;
    logic [HUW-1:0] h_used;
    logic [31:0]    w_ext, h_ext;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    // register writes complete in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_width  <= 7'd64;
            r_board_height <= 7'd64;
            r_rule_select  <= RULE_CONWAY;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_WIDTH:  r_board_width  <= pwdata[6:0];
                REG_HEIGHT: r_board_height <= pwdata[6:0];
                REG_RULE:   r_rule_select  <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {25'd0, r_board_width};
            REG_HEIGHT: prdata = {25'd0, r_board_height};
            REG_RULE:   prdata = {29'd0, r_rule_select};
            default:    prdata = '0;
        endcase
    end

    // zero size acts as one, oversize is clamped to the board storage
    always_comb begin
        w_ext = 32'(r_board_width);
        h_ext = 32'(r_board_height);
        if (w_ext == 0)              w_used = WUW'(1);
        else if (w_ext > MAX_WIDTH)  w_used = WUW'(MAX_WIDTH);
        else                         w_used = WUW'(w_ext);
        if (h_ext == 0)              h_used = HUW'(1);
        else if (h_ext > MAX_HEIGHT) h_used = HUW'(MAX_HEIGHT);
        else                         h_used = HUW'(h_ext);
    end

    llca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    llca_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_w_used            (w_used),
        .i_h_used            (h_used),
        .i_rule              (r_rule_select),
        .i_kind              (i_kind),
        .i_col               (i_col),
        .i_row               (i_row),
        .i_alive_in          (i_alive_in),
        .o_done              (o_done),
        .o_alive_out         (o_alive_out),
        .o_live_count        (o_live_count),
        .o_dead_count        (o_dead_count),
        .o_changed_count     (o_changed_count),
        .o_generation_number (o_generation_number)
    );

endmodule
`default_nettype wire
